>>> sv/imt_pkg.sv
// ----------------------------------------------------------------------------
// imt_pkg: shared types and constants
// Widths, status codes and payload structs for the interval map table.
// ----------------------------------------------------------------------------
`default_nettype none
package imt_pkg;
  localparam int TABLE_DEPTH = 16;
  localparam int KEY_BITS    = 32;
  localparam int VALUE_BITS  = 8;
  localparam int IDX_BITS    = $clog2(TABLE_DEPTH);
  localparam int CNT_BITS    = $clog2(TABLE_DEPTH + 1);
  localparam int QUEUE_DEPTH = 2;
  localparam int QPTR_BITS   = $clog2(QUEUE_DEPTH);
  localparam int QCNT_BITS   = $clog2(QUEUE_DEPTH + 1);

  typedef enum logic [1:0] {
    ST_DONE  = 2'd0,
    ST_EMPTY = 2'd1,
    ST_FULL  = 2'd2
  } status_t;

  typedef enum logic {
    ACT_LOOKUP = 1'b0,
    ACT_ASSIGN = 1'b1
  } action_t;

  typedef struct packed {
    logic                         action;
    logic signed [KEY_BITS-1:0]   key_begin;
    logic signed [KEY_BITS-1:0]   key_end;
    logic        [VALUE_BITS-1:0] new_value;
  } in_beat_t;

  typedef struct packed {
    logic [VALUE_BITS-1:0] found_value;
    logic [1:0]            status;
  } out_beat_t;

  // classified command passed from front to back
  typedef struct packed {
    logic                  is_assign;
    logic                  empty;
    logic [KEY_BITS-1:0]   kb;   // biased keys
    logic [KEY_BITS-1:0]   ke;
    logic [VALUE_BITS-1:0] val;
  } cmd_t;

  function automatic logic [KEY_BITS-1:0] bias(input logic [KEY_BITS-1:0] k);
    bias = k ^ {1'b1, {(KEY_BITS-1){1'b0}}};
  endfunction
endpackage
`default_nettype wire

>>> sv/imt_front.sv
// ----------------------------------------------------------------------------
// imt_front: input classification and command queue
// Biases keys, flags empty ranges, holds commands in a short FIFO.
// ----------------------------------------------------------------------------
`default_nettype none
module imt_front import imt_pkg::*; (
  input  wire logic     clk,
  input  wire logic     rst,
  input  wire in_beat_t in_data,
  input  wire logic     in_valid,
  output logic          in_ready,
  output cmd_t          cmd,
  output logic          cmd_valid,
  input  wire logic     cmd_ready
);
  cmd_t q [QUEUE_DEPTH];
  logic [QPTR_BITS-1:0] wp, rp;
  logic [QCNT_BITS-1:0] count;
  logic push, pop;
  cmd_t c;

  always_comb begin
    c.is_assign = (in_data.action == ACT_ASSIGN);
    c.kb        = bias(in_data.key_begin);
    c.ke        = bias(in_data.key_end);
    c.empty     = (c.kb >= c.ke);
    c.val       = in_data.new_value;
  end

  assign in_ready  = (count != QCNT_BITS'(QUEUE_DEPTH));
  assign cmd_valid = (count != '0);
  assign cmd       = q[rp];
  assign push      = in_valid && in_ready;
  assign pop       = cmd_valid && cmd_ready;

  always_ff @(posedge clk) begin
    if (push) q[wp] <= c;
    if (rst) begin
      wp <= '0; rp <= '0; count <= '0;
    end else begin
      if (push) wp <= (wp == QPTR_BITS'(QUEUE_DEPTH - 1)) ? '0 : wp + 1'b1;
      if (pop)  rp <= (rp == QPTR_BITS'(QUEUE_DEPTH - 1)) ? '0 : rp + 1'b1;
      count <= count + QCNT_BITS'(push) - QCNT_BITS'(pop);
    end
  end
endmodule
`default_nettype wire

>>> sv/imt_back.sv
// ----------------------------------------------------------------------------
// imt_back: breakpoint table engine
// Parallel compare in S_CMP; for an assign, rebuild of the table in S_UPD.
// ----------------------------------------------------------------------------
`default_nettype none
module imt_back import imt_pkg::*; (
  input  wire logic                  clk,
  input  wire logic                  rst,
  input  wire logic                  cfg_we,
  input  wire logic [VALUE_BITS-1:0] cfg_value,
  input  wire cmd_t                  cmd,
  input  wire logic                  cmd_valid,
  output logic                       cmd_ready,
  output out_beat_t                  out_data,
  output logic                       out_valid,
  input  wire logic                  out_ready
);
  typedef enum logic { S_CMP, S_UPD } state_t;
  state_t state;

  logic [KEY_BITS-1:0]   keys [TABLE_DEPTH];
  logic [VALUE_BITS-1:0] vals [TABLE_DEPTH];
  logic [CNT_BITS-1:0]   count;

  // compare results (registered)
  logic [CNT_BITS-1:0]   lo, rest;
  logic                  merge;
  logic [VALUE_BITS-1:0] end_val;
  cmd_t                  cur;

  logic [CNT_BITS-1:0] lo_c, hi_c;
  logic [TABLE_DEPTH-1:0] eq_e;
  always_comb begin
    lo_c = '0; hi_c = '0; eq_e = '0;
    for (int i = 0; i < TABLE_DEPTH; i++) begin
      if (CNT_BITS'(i) < count) begin
        if (keys[i] < cmd.kb) lo_c = lo_c + 1'b1;
        if (keys[i] < cmd.ke) hi_c = hi_c + 1'b1;
        eq_e[i] = (keys[i] == cmd.ke);
      end
    end
  end

  logic hi_exist;
  logic [IDX_BITS-1:0] hi_idx, him1_idx, lom1_idx;
  assign hi_idx   = hi_c[IDX_BITS-1:0];
  assign him1_idx = IDX_BITS'(hi_c - 1'b1);
  assign lom1_idx = IDX_BITS'(lo_c - 1'b1);
  assign hi_exist = (hi_c < count) && eq_e[hi_idx];

  // lookup: value of last key <= kb; lo_c counts keys < kb
  logic [IDX_BITS-1:0] lk_idx;
  always_comb begin
    if (lo_c < count && keys[lo_c[IDX_BITS-1:0]] == cmd.kb) lk_idx = lo_c[IDX_BITS-1:0];
    else lk_idx = lom1_idx;
  end

  logic                out_free;
  logic [CNT_BITS:0]   newcount;
  logic [CNT_BITS-1:0] ins;
  assign out_free  = !out_valid || out_ready;
  assign cmd_ready = (state == S_CMP) && out_free && !cfg_we;
  assign ins       = merge ? lo : lo + 1'b1;   // position of end breakpoint
  assign newcount  = (CNT_BITS+1)'(ins) + 1'b1 + (CNT_BITS+1)'(count - rest);

  always_ff @(posedge clk) begin
    if (rst || cfg_we) begin
      state     <= S_CMP;
      out_valid <= 1'b0;
      count     <= CNT_BITS'(1);
      keys[0]   <= '0;
      vals[0]   <= rst ? '0 : cfg_value;
    end else begin
      if (out_valid && out_ready) out_valid <= 1'b0;
      case (state)
        S_CMP: begin
          if (cmd_valid && cmd_ready) begin
            cur <= cmd;
            if (!cmd.is_assign) begin
              out_valid <= 1'b1;
              out_data  <= '{found_value: vals[lk_idx], status: ST_DONE};
            end else if (cmd.empty) begin
              out_valid <= 1'b1;
              out_data  <= '{found_value: '0, status: ST_EMPTY};
            end else begin
              lo      <= lo_c;
              rest    <= hi_c + CNT_BITS'(hi_exist);
              end_val <= hi_exist ? vals[hi_idx] : vals[him1_idx];
              merge   <= (lo_c != '0) && (vals[lom1_idx] == cmd.val);
              state   <= S_UPD;
            end
          end
        end
        S_UPD: begin
          state     <= S_CMP;
          out_valid <= 1'b1;
          if (newcount > (CNT_BITS+1)'(TABLE_DEPTH)) begin
            out_data <= '{found_value: '0, status: ST_FULL};
          end else begin
            out_data <= '{found_value: '0, status: ST_DONE};
            // shift pass: entry j of new table from old table
            for (int j = 0; j < TABLE_DEPTH; j++) begin
              if (CNT_BITS'(j) == lo && !merge) begin
                keys[j] <= cur.kb; vals[j] <= cur.val;
              end else if (CNT_BITS'(j) == ins) begin
                keys[j] <= cur.ke; vals[j] <= end_val;
              end else if (CNT_BITS'(j) > ins) begin
                keys[j] <= keys[IDX_BITS'(CNT_BITS'(j) - ins - 1'b1 + rest)];
                vals[j] <= vals[IDX_BITS'(CNT_BITS'(j) - ins - 1'b1 + rest)];
              end
            end
            count <= newcount[CNT_BITS-1:0];
          end
        end
        default: state <= S_CMP;
      endcase
    end
  end
endmodule
`default_nettype wire

>>> sv/interval_map_table.sv
// ----------------------------------------------------------------------------
// interval_map_table: sorted breakpoint range map
// Range assign and point lookup over a 16-entry signed-key table.
// ----------------------------------------------------------------------------
// Every key maps to the value of the last breakpoint at or below it. A lookup
// is answered by the back engine's parallel compare over all breakpoints;
// an assign follows that compare with a table rebuild pass. A two-beat
// command queue sits between input and engine. Writing cfg_data resets
// the table at once; write only while idle. Results come one beat per item,
// in order, with status done, empty range or table full.
// ----------------------------------------------------------------------------
`default_nettype none
module interval_map_table import imt_pkg::*; (
  input  wire logic                  clk,
  input  wire logic                  rst,
  input  wire logic                  cfg_we,
  input  wire logic [VALUE_BITS-1:0] cfg_data,
  input  wire in_beat_t              in_data,
  input  wire logic                  in_valid,
  output logic                       in_ready,
  output out_beat_t                  out_data,
  output logic                       out_valid,
  input  wire logic                  out_ready
);
  cmd_t cmd;
  logic cmd_valid, cmd_ready;

  // front: classify and queue
  imt_front u_front (
    .clk, .rst, .in_data, .in_valid, .in_ready,
    .cmd, .cmd_valid, .cmd_ready
  );

  // back: table engine with registered result beat
  imt_back u_back (
    .clk, .rst, .cfg_we, .cfg_value(cfg_data),
    .cmd, .cmd_valid, .cmd_ready,
    .out_data, .out_valid, .out_ready
  );
endmodule
`default_nettype wire

>>> sv/imt_checker.sv
// ----------------------------------------------------------------------------
// imt_checker: port-level checks
// Watches result beats of the interval map table.
// ----------------------------------------------------------------------------
`default_nettype none
module imt_checker import imt_pkg::*; (
  input wire logic      clk,
  input wire logic      rst,
  input wire logic      out_valid,
  input wire logic      out_ready,
  input wire out_beat_t out_data
);
  a_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(out_data))
    else $error("result beat dropped or changed while stalled");
  a_status: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> out_data.status != 2'd3)
    else $error("bad status code");
  a_zero: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_data.status != ST_DONE |-> out_data.found_value == '0)
    else $error("rejected assign carries a value");
  a_rst: assert property (@(posedge clk) rst |=> !out_valid)
    else $error("result beat after reset");
endmodule

bind interval_map_table imt_checker u_chk (
  .clk, .rst, .out_valid, .out_ready, .out_data
);
`default_nettype wire
